/* sv/arpc_pkg.sv */
package arpc_pkg;

    localparam int CACHE_ENTRIES = 8;
    localparam int IDX_W         = $clog2(CACHE_ENTRIES);

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // configuration port
    localparam int CFG_AW = 3;
    localparam logic REG_MY_IP    = 1'b0;
    localparam logic REG_PROBE_IP = 1'b1;

    // op field codes
    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_STORE  = 2'd2;
    localparam logic [1:0] OP_FLUSH  = 2'd3;

    // ARP opcodes
    localparam logic [15:0] ARP_OPC_REQ = 16'd1;
    localparam logic [15:0] ARP_OPC_RSP = 16'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] arp_operation;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [31:0] target_ip;
    } t_item;

    typedef struct packed {
        logic        status;
        logic        hit;
        logic [47:0] found_mac;
        logic        send_reply;
        logic [31:0] reply_ip;
        logic [47:0] reply_mac;
        logic        probe_conflict;
        logic        ip_in_use_warning;
    } t_result;

    typedef struct packed {
        logic [31:0] my_ip;
        logic [31:0] probe_ip;
    } t_cfg;

    typedef enum logic [1:0] {
        K_NONE,
        K_LOOKUP,
        K_STORE,
        K_FLUSH
    } t_kind;

    // classified command handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [31:0] key_ip;
        logic [47:0] mac;
        logic        status;
        logic        send_reply;
        logic        probe_conflict;
        logic        ip_in_use_warning;
    } t_cmd;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } t_entry;

endpackage

/* sv/arp_cache_receive_engine.sv */
// Channel   Direction  Handshake                   Payload
// item      in         push / full                 i_item   (t_item)
// result    out        pop / empty                 o_result (t_result)
// config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// A lookup or store scans every cache entry between accept and result; the scan
// reads and compares one entry per cycle.
// Flushes and packets that need no cache access skip the scan.
// The front queue holds two classified items, so pushes continue while the
// back end scans or while a result waits for pop.
// Reset is synchronous, active low; the cache is empty right after reset.
module arp_cache_receive_engine
    import arpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  t_item             i_item,
    output logic              empty,
    input  logic              pop,
    output t_result           o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0] r_my_ip;
    logic [31:0] r_probe_ip;
    t_cfg        w_cfg;
    logic        w_cmd_vld;
    logic        w_cmd_pop;
    t_cmd        w_cmd;

    assign pready         = 1'b1;
    assign w_cfg.my_ip    = r_my_ip;
    assign w_cfg.probe_ip = r_probe_ip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_ip    <= '0;
            r_probe_ip <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_MY_IP:    r_my_ip    <= pwdata;
                REG_PROBE_IP: r_probe_ip <= pwdata;
                default:      r_my_ip    <= r_my_ip;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MY_IP:    prdata = r_my_ip;
            REG_PROBE_IP: prdata = r_probe_ip;
            default:      prdata = '0;
        endcase
    end

    arpc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .i_cfg     (w_cfg),
        .o_cmd_vld (w_cmd_vld),
        .o_cmd     (w_cmd),
        .i_cmd_pop (w_cmd_pop)
    );

    arpc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (w_cmd_vld),
        .i_cmd     (w_cmd),
        .o_cmd_pop (w_cmd_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

/* sv/arpc_ram.sv */
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/arpc_front.sv */
module arpc_front
    import arpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  t_cfg  i_cfg,
    output logic  o_cmd_vld,
    output t_cmd  o_cmd,
    input  logic  i_cmd_pop
);

    t_cmd            r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;
    t_cmd            n_cmd;
    logic            w_push;
    logic            w_pop;

    // classify the incoming item
    always_comb begin
        n_cmd            = '0;
        n_cmd.kind       = K_NONE;
        n_cmd.key_ip     = i_item.sender_ip;
        n_cmd.mac        = i_item.sender_mac;
        case (i_item.op)
            OP_PACKET: begin
                n_cmd.probe_conflict = (i_item.sender_ip == 32'd0) &&
                                       (i_item.target_ip == i_cfg.probe_ip);
                if (i_item.arp_operation == ARP_OPC_REQ) begin
                    if (i_item.target_ip == i_cfg.my_ip) begin
                        n_cmd.kind       = K_STORE;
                        n_cmd.send_reply = 1'b1;
                    end
                end else if (i_item.arp_operation == ARP_OPC_RSP) begin
                    if (i_item.target_ip == i_cfg.my_ip) begin
                        n_cmd.kind              = K_STORE;
                        n_cmd.ip_in_use_warning = (i_item.target_ip == i_item.sender_ip);
                    end
                end else begin
                    n_cmd.status = 1'b1;
                end
            end
            OP_LOOKUP: begin
                n_cmd.kind   = K_LOOKUP;
                n_cmd.key_ip = i_item.target_ip;
            end
            OP_STORE: begin
                n_cmd.kind = K_STORE;
            end
            default: begin
                n_cmd.kind = K_FLUSH;
            end
        endcase
    end

    assign o_full    = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_cmd_vld = (r_cnt != '0);
    assign o_cmd     = r_q[r_rp];
    assign w_push    = i_push && !o_full;
    assign w_pop     = i_cmd_pop && o_cmd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= n_cmd;
                r_wp      <= (r_wp == Q_AW'(Q_DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* sv/arpc_back.sv */
module arpc_back
    import arpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_vld,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [IDX_W:0]     r_idx;
    logic               r_chk_vld;
    logic [IDX_W-1:0]   r_chk_idx;
    logic               r_found;
    logic [47:0]        r_found_mac;
    logic [CACHE_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]   r_next_slot;
    logic               r_out_vld;
    t_result            r_out;

    t_entry  w_rd;
    logic    w_issue;
    logic    w_match;
    logic    w_out_free;
    logic    w_out_load;
    logic    w_store;
    t_result n_out;

    assign w_issue    = (r_state == S_SCAN) && (r_idx != (IDX_W+1)'(CACHE_ENTRIES));
    assign w_match    = r_chk_vld && r_valid[r_chk_idx] && (w_rd.ip == r_cmd.key_ip);
    assign w_out_free = !r_out_vld || i_pop;
    assign w_out_load = (r_state == S_EXEC) && w_out_free;
    assign w_store    = w_out_load && (r_cmd.kind == K_STORE) && !r_found;
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_vld;
    assign o_empty    = !r_out_vld;
    assign o_result   = r_out;

    arpc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CACHE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_next_slot),
        .i_wdata ({r_cmd.key_ip, r_cmd.mac}),
        .i_re    (w_issue),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rd)
    );

    always_comb begin
        n_out                   = '0;
        n_out.status            = r_cmd.status;
        n_out.hit               = (r_cmd.kind == K_LOOKUP) && r_found;
        n_out.found_mac         = n_out.hit ? r_found_mac : 48'd0;
        n_out.send_reply        = r_cmd.send_reply;
        n_out.reply_ip          = r_cmd.send_reply ? r_cmd.key_ip : 32'd0;
        n_out.reply_mac         = r_cmd.send_reply ? r_cmd.mac : 48'd0;
        n_out.probe_conflict    = r_cmd.probe_conflict;
        n_out.ip_in_use_warning = r_cmd.ip_in_use_warning;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_valid     <= '0;
            r_next_slot <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_pop && r_out_vld) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_vld) begin
                        r_cmd     <= i_cmd;
                        r_idx     <= '0;
                        r_chk_vld <= 1'b0;
                        r_found   <= 1'b0;
                        if (i_cmd.kind == K_LOOKUP || i_cmd.kind == K_STORE) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_SCAN: begin
                    // one entry read per cycle, compared in the following cycle
                    if (w_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_chk_vld <= w_issue;
                    r_chk_idx <= r_idx[IDX_W-1:0];
                    if (w_match && !r_found) begin
                        r_found     <= 1'b1;
                        r_found_mac <= w_rd.mac;
                    end
                    if (!w_issue && !r_chk_vld) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // hold until the result register can take the beat
                    if (w_out_free) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                        if (w_store) begin
                            r_valid[r_next_slot] <= 1'b1;
                            r_next_slot <= (r_next_slot == IDX_W'(CACHE_ENTRIES-1)) ?
                                           '0 : r_next_slot + 1'b1;
                        end
                        if (r_cmd.kind == K_FLUSH) begin
                            r_valid     <= '0;
                            r_next_slot <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/arpc_checker.sv */
module arpc_checker
    import arpc_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    push,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    logic [2:0] r_outstanding;

    // count beats in flight between the two queue ports
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            case ({push && !full, pop && !empty})
                2'b10:   r_outstanding <= r_outstanding + 1'b1;
                2'b01:   r_outstanding <= r_outstanding - 1'b1;
                default: r_outstanding <= r_outstanding;
            endcase
        end
    end

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_outstanding != 3'd0) && (r_outstanding <= 3'(Q_DEPTH + 2)))
        else $error("result shown with no item outstanding, or too many in flight");

    a_miss_mac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.hit) |-> (o_result.found_mac == 48'd0))
        else $error("found_mac nonzero on a miss");

    a_hit_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.hit) |-> (!o_result.send_reply && !o_result.status &&
                                      !o_result.probe_conflict &&
                                      !o_result.ip_in_use_warning))
        else $error("lookup hit mixed with packet flags");

    a_reply_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.send_reply) |->
            (o_result.reply_ip == 32'd0) && (o_result.reply_mac == 48'd0))
        else $error("reply fields nonzero without send_reply");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result dropped or changed");

endmodule

bind arp_cache_receive_engine arpc_checker u_arpc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

/* bench/arp_cache_receive_engine_tb.sv */
module arp_cache_receive_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arpc_pkg::*;

    localparam logic [CFG_AW-1:0] ADDR_MY_IP    = {REG_MY_IP, 2'b00};
    localparam logic [CFG_AW-1:0] ADDR_PROBE_IP = {REG_PROBE_IP, 2'b00};
    localparam logic [31:0]       DIR_MY_IP     = 32'hC0A8_0001;
    localparam logic [31:0]       DIR_PROBE_IP  = 32'hA9FE_1234;
    localparam int                PHASES        = 8;
    localparam int                PHASE_ITEMS   = 250;
    localparam int                POOL_SIZE     = 12;
    localparam int                DRAIN_CYCLES  = 40;
    localparam int                MAX_PRINTS    = 100;
    localparam t_result           NO_RESULT     = '0;

    typedef struct {
        t_item   item;
        bit      typed;
        t_result want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    t_item             i_item;
    logic              empty;
    logic              pop;
    t_result           o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // predictor state
    logic [31:0] cfg_my_ip;
    logic [31:0] cfg_probe_ip;
    logic [31:0] cache_ip  [CACHE_ENTRIES];
    logic [47:0] cache_mac [CACHE_ENTRIES];
    bit          cache_vld [CACHE_ENTRIES];
    int          rr_slot;

    t_result     pending_results[$];
    t_row        dir_rows[$];
    logic [31:0] ip_pool[POOL_SIZE];
    bit          no_idle;
    int          mismatch_count;
    int          results_seen;

    arp_cache_receive_engine DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void cache_clear();
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            cache_ip[i]  = '0;
            cache_mac[i] = '0;
            cache_vld[i] = 1'b0;
        end
        rr_slot = 0;
    endfunction

    function automatic int cache_find(logic [31:0] ip);
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (cache_vld[i] && cache_ip[i] == ip)
                return i;
        end
        return -1;
    endfunction

    // keep an existing MAC; otherwise fill the round-robin slot
    function automatic void cache_insert(logic [31:0] ip, logic [47:0] mac);
        if (cache_find(ip) >= 0)
            return;
        cache_ip[rr_slot]  = ip;
        cache_mac[rr_slot] = mac;
        cache_vld[rr_slot] = 1'b1;
        rr_slot = (rr_slot == CACHE_ENTRIES - 1) ? 0 : rr_slot + 1;
    endfunction

    function automatic t_result predict_arp(t_item it);
        t_result r;
        int      k;
        r = '0;
        case (it.op)
            OP_PACKET: begin
                // probe check runs before the opcode is looked at
                if (it.sender_ip == '0 && it.target_ip == cfg_probe_ip)
                    r.probe_conflict = 1'b1;
                if (it.arp_operation == ARP_OPC_REQ) begin
                    if (it.target_ip == cfg_my_ip) begin
                        cache_insert(it.sender_ip, it.sender_mac);
                        r.send_reply = 1'b1;
                        r.reply_ip   = it.sender_ip;
                        r.reply_mac  = it.sender_mac;
                    end
                end else if (it.arp_operation == ARP_OPC_RSP) begin
                    if (it.target_ip == cfg_my_ip) begin
                        if (it.target_ip == it.sender_ip)
                            r.ip_in_use_warning = 1'b1;
                        cache_insert(it.sender_ip, it.sender_mac);
                    end
                end else begin
                    r.status = 1'b1;
                end
            end
            OP_LOOKUP: begin
                k = cache_find(it.target_ip);
                if (k >= 0) begin
                    r.hit       = 1'b1;
                    r.found_mac = cache_mac[k];
                end
            end
            OP_STORE: cache_insert(it.sender_ip, it.sender_mac);
            default:  cache_clear();
        endcase
        return r;
    endfunction

    function automatic t_item arp_item(logic [1:0] op, logic [15:0] opc, logic [31:0] sip,
                                       logic [47:0] smac, logic [31:0] tip);
        t_item it;
        it.op            = op;
        it.arp_operation = opc;
        it.sender_ip     = sip;
        it.sender_mac    = smac;
        it.target_ip     = tip;
        return it;
    endfunction

    function automatic logic [31:0] pick_ip();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return cfg_my_ip;
            2:       return cfg_probe_ip;
            default: return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t ns: result %0d: %s", $time, results_seen, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MY_IP)
            cfg_my_ip = data;
        else
            cfg_probe_ip = data;
        // bus idle between transfers
        @(posedge i_clk);
    endtask

    task automatic send_item(input t_item it, input bit typed, input t_result want);
        int      gap;
        t_result predicted;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full !== 1'b0);
        predicted = predict_arp(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // hold off new items until every result has come back
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : result_sink
        int      stall;
        t_result want;
        pop <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                want = pending_results.pop_front();
                check_field("status", o_result.status, want.status);
                check_field("hit", o_result.hit, want.hit);
                check_field("found_mac", o_result.found_mac, want.found_mac);
                check_field("send_reply", o_result.send_reply, want.send_reply);
                check_field("reply_ip", o_result.reply_ip, want.reply_ip);
                check_field("reply_mac", o_result.reply_mac, want.reply_mac);
                check_field("probe_conflict", o_result.probe_conflict, want.probe_conflict);
                check_field("ip_in_use_warning", o_result.ip_in_use_warning,
                            want.ip_in_use_warning);
            end
            results_seen++;
        end
    end

    initial begin : stimulus
        t_item       it;
        int          sel;
        logic [31:0] word;
        i_rst_n        <= 1'b0;
        push           <= 1'b0;
        i_item         <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        no_idle        = 1'b0;
        mismatch_count = 0;
        results_seen   = 0;
        cfg_my_ip      = '0;
        cfg_probe_ip   = '0;
        cache_clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(ADDR_MY_IP, DIR_MY_IP);
        write_reg(ADDR_PROBE_IP, DIR_PROBE_IP);

        // empty cache misses, IP zero included
        dir_rows.push_back('{arp_item(OP_LOOKUP, 16'h0, '0, '0, '0), 1'b1, NO_RESULT});
        dir_rows.push_back('{arp_item(OP_LOOKUP, '1, '1, '1, '1), 1'b1, NO_RESULT});
        // bad opcodes: error status, probe still checked, cache untouched
        dir_rows.push_back('{arp_item(OP_PACKET, 16'h0, '0, '0, DIR_PROBE_IP), 1'b1,
                             t_result'{1'b1, 1'b0, 48'h0, 1'b0, 32'h0, 48'h0, 1'b1, 1'b0}});
        dir_rows.push_back('{arp_item(OP_PACKET, '1, '1, '1, DIR_MY_IP), 1'b1,
                             t_result'{1'b1, 1'b0, 48'h0, 1'b0, 32'h0, 48'h0, 1'b0, 1'b0}});
        dir_rows.push_back('{arp_item(OP_PACKET, 16'h3, 32'h0A00_0001, 48'h1, DIR_MY_IP), 1'b1,
                             t_result'{1'b1, 1'b0, 48'h0, 1'b0, 32'h0, 48'h0, 1'b0, 1'b0}});
        dir_rows.push_back('{arp_item(OP_LOOKUP, 16'h0, '0, '0, '1), 1'b1, NO_RESULT});
        // request for this node: reply carries the requester
        dir_rows.push_back('{arp_item(OP_PACKET, ARP_OPC_REQ, 32'h0A00_0001,
                                      48'h0011_2233_4455, DIR_MY_IP), 1'b1,
                             t_result'{1'b0, 1'b0, 48'h0, 1'b1, 32'h0A00_0001,
                                       48'h0011_2233_4455, 1'b0, 1'b0}});
        dir_rows.push_back('{arp_item(OP_LOOKUP, 16'h0, '0, '0, 32'h0A00_0001), 1'b0, NO_RESULT});
        // second request from the same IP must not replace the MAC
        dir_rows.push_back('{arp_item(OP_PACKET, ARP_OPC_REQ, 32'h0A00_0001,
                                      48'h6677_8899_AABB, DIR_MY_IP), 1'b0, NO_RESULT});
        dir_rows.push_back('{arp_item(OP_LOOKUP, 16'h0, '0, '0, 32'h0A00_0001), 1'b0, NO_RESULT});
        dir_rows.push_back('{arp_item(OP_PACKET, ARP_OPC_RSP, DIR_MY_IP,
                                      48'hDEAD_BEEF_0001, DIR_MY_IP), 1'b0, NO_RESULT});
        // packets for someone else
        dir_rows.push_back('{arp_item(OP_PACKET, ARP_OPC_REQ, 32'h0A00_0002, 48'h2,
                                      32'h0A00_0003), 1'b0, NO_RESULT});
        dir_rows.push_back('{arp_item(OP_PACKET, ARP_OPC_RSP, 32'h0A00_0004, 48'h4,
                                      32'h0A00_0005), 1'b0, NO_RESULT});
        dir_rows.push_back('{arp_item(OP_LOOKUP, 16'h0, '0, '0, 32'h0A00_0004), 1'b0, NO_RESULT});
        // IP zero may be stored by hand
        dir_rows.push_back('{arp_item(OP_STORE, 16'h0, '0, '1, '0), 1'b0, NO_RESULT});
        dir_rows.push_back('{arp_item(OP_LOOKUP, 16'h0, '0, '0, '0), 1'b0, NO_RESULT});
        dir_rows.push_back('{arp_item(OP_PACKET, ARP_OPC_REQ, '0, '0, DIR_PROBE_IP),
                             1'b0, NO_RESULT});
        dir_rows.push_back('{arp_item(OP_PACKET, ARP_OPC_RSP, '0, 48'h5, DIR_MY_IP),
                             1'b0, NO_RESULT});
        dir_rows.push_back('{arp_item(OP_STORE, 16'h0, '1, '0, '0), 1'b0, NO_RESULT});
        dir_rows.push_back('{arp_item(OP_LOOKUP, 16'h0, '0, '0, '1), 1'b0, NO_RESULT});
        // flush, then nothing matches
        dir_rows.push_back('{arp_item(OP_FLUSH, '1, '1, '1, '1), 1'b1, NO_RESULT});
        dir_rows.push_back('{arp_item(OP_LOOKUP, 16'h0, '0, '0, '0), 1'b1, NO_RESULT});
        dir_rows.push_back('{arp_item(OP_LOOKUP, 16'h0, '0, '0, 32'h0A00_0001), 1'b1, NO_RESULT});
        dir_rows.push_back('{arp_item(OP_LOOKUP, 16'h0, '0, '0, '1), 1'b1, NO_RESULT});

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    write_reg(ADDR_MY_IP, '0);
                    write_reg(ADDR_PROBE_IP, '0);
                end
                1: begin
                    write_reg(ADDR_MY_IP, '1);
                    write_reg(ADDR_PROBE_IP, '1);
                end
                2: begin
                    // probing our own address
                    word = $urandom;
                    write_reg(ADDR_MY_IP, word);
                    write_reg(ADDR_PROBE_IP, word);
                end
                default: begin
                    write_reg(ADDR_MY_IP, $urandom);
                    write_reg(ADDR_PROBE_IP, $urandom);
                end
            endcase
            ip_pool[0] = '0;
            ip_pool[1] = '1;
            for (int k = 2; k < POOL_SIZE; k++)
                ip_pool[k] = $urandom;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                sel = $urandom_range(0, 99);
                it.op = (sel < 45) ? OP_PACKET : (sel < 75) ? OP_LOOKUP :
                        (sel < 97) ? OP_STORE : OP_FLUSH;
                sel = $urandom_range(0, 9);
                it.arp_operation = (sel < 4) ? ARP_OPC_REQ : (sel < 8) ? ARP_OPC_RSP :
                                   (sel == 8) ? 16'($urandom_range(0, 3)) : 16'($urandom);
                it.sender_ip = ($urandom_range(0, 6) == 0) ? '0 : pick_ip();
                sel = $urandom_range(0, 9);
                it.target_ip = (sel < 5) ? cfg_my_ip : (sel < 7) ? cfg_probe_ip : pick_ip();
                if (it.op != OP_PACKET)
                    it.target_ip = pick_ip();
                else if (it.arp_operation == ARP_OPC_RSP && $urandom_range(0, 9) == 0)
                    it.sender_ip = it.target_ip;
                sel = $urandom_range(0, 9);
                it.sender_mac = (sel == 0) ? '0 : (sel == 1) ? '1 :
                                {16'($urandom), 32'($urandom)};
                send_item(it, 1'b0, NO_RESULT);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("arp_cache_receive_engine_tb: PASS");
        else
            $display("arp_cache_receive_engine_tb: FAIL");
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("arp_cache_receive_engine_tb: FAIL");
        $finish;
    end

endmodule
